[rtl/core/topological_sort_engine_defines.svh]
// ---------------------------------------------------------------------------
// Topological sort engine assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef TOPOLOGICAL_SORT_ENGINE_DEFINES_SVH
`define TOPOLOGICAL_SORT_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// prop is checked on every rising clk edge outside of reset
`define TSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// pre holds in one cycle, post holds in the next
`define TSE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TSE_ASSERT(label, prop, msg)
`define TSE_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

[rtl/core/tse_pkg.sv]
// ---------------------------------------------------------------------------
// Topological sort engine package
// Sizes, command and result types, status codes and the edge limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tse_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int EDGE_W       = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
    localparam int FIELD_W      = 6;

    typedef enum logic [1:0] {
        MODE_EDGE  = 2'd0,
        MODE_SORT  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADV    = 2'd1,
        ST_TOOMANY = 2'd2,
        ST_CYCLE   = 2'd3
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [FIELD_W-1:0] from_vertex;
        logic [FIELD_W-1:0] to_vertex;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0] vertex;
        status_t            status;
        logic               last;
    } result_t;

    // n(n-1)/2, zero for n = 0
    function automatic logic [EDGE_W-1:0] edge_limit(input logic [CNT_W-1:0] n);
        logic [2*CNT_W-1:0] prod;
        prod = (2*CNT_W)'(n) * (2*CNT_W)'(n - CNT_W'(1));
        return EDGE_W'(prod >> 1);
    endfunction

endpackage

[rtl/core/tse_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/topological_sort_engine.sv]
// ---------------------------------------------------------------------------
// Topological sort engine
// Loads directed edges into a bit adjacency matrix and runs Kahn's sort.
// ---------------------------------------------------------------------------
// Edge item: row read, then row write in S_EWR; errors show in the cycle after accept.
// Sort item, n vertices: clear in-degrees, count them row by row, queue the zero ones,
//   pop and release; then n results go out back to back, registered onto the bus. Bound
//   by the serial column scan through the in-degree RAM. Clear, config, ignored: stay idle.
// Reset (async, rst_n low) drops all matrix row valid bits, zeroes edge count and
//   queue pointers and sets node_count to 1; no clearing pass. Results cannot stall.
`timescale 1ns / 1ps
`include "topological_sort_engine_defines.svh"

module topological_sort_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tse_pkg::cmd_t                 cmd,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tse_pkg::FIELD_W-1:0]   cfg_data,
    output logic                          result_valid,
    output tse_pkg::result_t              result
);

    import tse_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_EWR   = 15'b000000000000010,
        S_DCLR  = 15'b000000000000100,
        S_DROW  = 15'b000000000001000,
        S_DLAT  = 15'b000000000010000,
        S_DSCAN = 15'b000000000100000,
        S_DINC  = 15'b000000001000000,
        S_QRD   = 15'b000000010000000,
        S_QCHK  = 15'b000000100000000,
        S_POP   = 15'b000001000000000,
        S_PLAT  = 15'b000010000000000,
        S_PSCAN = 15'b000100000000000,
        S_PDEC  = 15'b001000000000000,
        S_DONE  = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [FIELD_W-1:0]      node_count_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [EDGE_W-1:0]       edges_reg, edges_next;
    logic [VTX_W-1:0]        i_reg, i_next;
    logic [VTX_W-1:0]        j_reg, j_next;
    logic [CNT_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        tail_reg, tail_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic                    adj_rvalid_reg;
    logic [VTX_W-1:0]        edge_row_reg, edge_row_next;
    logic [VTX_W-1:0]        edge_col_reg, edge_col_next;
    logic [VTX_W-1:0]        queue_reg [MAX_VERTICES];
    result_t                 res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;

    logic                    adj_we;
    logic [VTX_W-1:0]        adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
    logic                    deg_we;
    logic [VTX_W-1:0]        deg_waddr, deg_raddr;
    logic [CNT_W-1:0]        deg_wdata, deg_rdata;
    logic                    q_we;

    logic [CNT_W-1:0]        n_act;
    logic                    j_last, i_last;
    logic                    from_ok, to_ok;
    logic [MAX_VERTICES-1:0] row_base, col_bit;
    logic [CNT_W-1:0]        deg_dec;
    logic                    deg_step, rel_step;

    tse_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    tse_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = !busy;
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    always_comb
    begin
        if (int'(node_count_reg) > MAX_VERTICES)
        begin
            n_act = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_act = CNT_W'(node_count_reg);
        end
    end

    assign j_last  = (j_reg == VTX_W'(n_act - CNT_W'(1)));
    assign i_last  = (i_reg == VTX_W'(n_act - CNT_W'(1)));
    assign from_ok = (cmd.from_vertex != '0) && (int'(cmd.from_vertex) <= int'(n_act));
    assign to_ok   = (cmd.to_vertex != '0) && (int'(cmd.to_vertex) <= int'(n_act));
    // invalid rows read as zero
    assign row_base = adj_rvalid_reg ? adj_rdata : '0;
    assign deg_dec  = deg_rdata - CNT_W'(1);

    always_comb
    begin
        col_bit               = '0;
        col_bit[edge_col_reg] = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        edges_next     = edges_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        row_next       = row_reg;
        edge_row_next  = edge_row_reg;
        edge_col_next  = edge_col_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        adj_we         = 1'b0;
        adj_waddr      = edge_row_reg;
        adj_wdata      = row_base | col_bit;
        adj_raddr      = i_reg;
        deg_we         = 1'b0;
        deg_waddr      = j_reg;
        deg_wdata      = '0;
        deg_raddr      = j_reg;
        q_we           = 1'b0;
        deg_step       = 1'b0;
        rel_step       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.mode)
                        MODE_EDGE:
                        begin
                            // edge limit is checked before the endpoints
                            if (edges_reg >= edge_limit(n_act))
                            begin
                                res_next       = '{vertex: '0, status: ST_TOOMANY, last: 1'b1};
                                res_valid_next = 1'b1;
                            end
                            else if (!from_ok || !to_ok)
                            begin
                                res_next       = '{vertex: '0, status: ST_BADV, last: 1'b1};
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                adj_raddr     = VTX_W'(cmd.from_vertex - FIELD_W'(1));
                                edge_row_next = VTX_W'(cmd.from_vertex - FIELD_W'(1));
                                edge_col_next = VTX_W'(cmd.to_vertex - FIELD_W'(1));
                                state_next    = S_EWR;
                            end
                        end
                        MODE_SORT:
                        begin
                            if (n_act != '0)
                            begin
                                j_next     = '0;
                                state_next = S_DCLR;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            row_valid_next = '0;
                            edges_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EWR:
            begin
                adj_we                       = 1'b1;
                row_valid_next[edge_row_reg] = 1'b1;
                edges_next                   = edges_reg + EDGE_W'(1);
                state_next                   = S_IDLE;
            end
            S_DCLR:
            begin
                deg_we = 1'b1;
                if (j_last)
                begin
                    i_next     = '0;
                    state_next = S_DROW;
                end
                else
                begin
                    j_next = j_reg + VTX_W'(1);
                end
            end
            S_DROW:
            begin
                state_next = S_DLAT;
            end
            S_DLAT:
            begin
                row_next   = row_base;
                j_next     = '0;
                state_next = S_DSCAN;
            end
            S_DSCAN:
            begin
                if (row_reg[j_reg])
                begin
                    state_next = S_DINC;
                end
                else
                begin
                    deg_step = 1'b1;
                end
            end
            S_DINC:
            begin
                deg_we    = 1'b1;
                deg_wdata = deg_rdata + CNT_W'(1);
                deg_step  = 1'b1;
            end
            S_QRD:
            begin
                state_next = S_QCHK;
            end
            S_QCHK:
            begin
                if (deg_rdata == '0)
                begin
                    q_we      = 1'b1;
                    tail_next = tail_reg + CNT_W'(1);
                end
                if (j_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    j_next     = j_reg + VTX_W'(1);
                    state_next = S_QRD;
                end
            end
            S_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    adj_raddr  = queue_reg[head_reg[VTX_W-1:0]];
                    head_next  = head_reg + CNT_W'(1);
                    state_next = S_PLAT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PLAT:
            begin
                row_next   = row_base;
                j_next     = '0;
                state_next = S_PSCAN;
            end
            S_PSCAN:
            begin
                if (row_reg[j_reg])
                begin
                    state_next = S_PDEC;
                end
                else
                begin
                    rel_step = 1'b1;
                end
            end
            S_PDEC:
            begin
                deg_we    = 1'b1;
                deg_wdata = deg_dec;
                if ((deg_dec == '0) && !tail_reg[VTX_W])
                begin
                    q_we      = 1'b1;
                    tail_next = tail_reg + CNT_W'(1);
                end
                rel_step = 1'b1;
            end
            S_DONE:
            begin
                // queue holds the pop order; replay it only if every vertex came out
                if (tail_reg == n_act)
                begin
                    head_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    res_next       = '{vertex: '0, status: ST_CYCLE, last: 1'b1};
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_OUT:
            begin
                res_next.vertex = FIELD_W'(queue_reg[head_reg[VTX_W-1:0]]) + FIELD_W'(1);
                res_next.status = ST_OK;
                res_next.last   = (head_reg == n_act - CNT_W'(1));
                res_valid_next  = 1'b1;
                head_next       = head_reg + CNT_W'(1);
                if (head_reg == n_act - CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (deg_step)
        begin
            if (j_last)
            begin
                if (i_last)
                begin
                    j_next     = '0;
                    head_next  = '0;
                    tail_next  = '0;
                    state_next = S_QRD;
                end
                else
                begin
                    i_next     = i_reg + VTX_W'(1);
                    state_next = S_DROW;
                end
            end
            else
            begin
                j_next     = j_reg + VTX_W'(1);
                state_next = S_DSCAN;
            end
        end

        if (rel_step)
        begin
            if (j_last)
            begin
                state_next = S_POP;
            end
            else
            begin
                j_next     = j_reg + VTX_W'(1);
                state_next = S_PSCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= FIELD_W'(1);
            row_valid_reg  <= '0;
            edges_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            edges_reg     <= edges_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        row_reg        <= row_next;
        edge_row_reg   <= edge_row_next;
        edge_col_reg   <= edge_col_next;
        res_reg        <= res_next;
        adj_rvalid_reg <= row_valid_reg[adj_raddr];
        if (q_we)
        begin
            queue_reg[tail_reg[VTX_W-1:0]] <= j_reg;
        end
    end

    `TSE_ASSERT(a_ok_vertex, result_valid && (result.status == ST_OK) |-> (result.vertex != '0), "ordered result carries vertex zero")
    `TSE_ASSERT(a_err_single, result_valid && (result.status != ST_OK) |-> result.last && (result.vertex == '0), "error result not a lone final transfer")
    `TSE_ASSERT(a_quiet_release, (state_reg == S_PSCAN) |-> !result_valid, "result strobe during release pass")
    `TSE_ASSERT(a_head_tail, (state_reg == S_POP) |-> (head_reg <= tail_reg), "queue head passed tail")
    `TSE_ASSERT_NEXT(a_edge_count, state_reg == S_EWR, edges_reg == $past(edges_reg) + EDGE_W'(1), "edge write did not count")

endmodule

[bench/topological_sort_engine_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Topological sort engine testbench
// Walks a stimulus table: a short directed part for the edge limit, bad
// endpoints, self loops, stale rows and vertex count extremes, then random
// graph phases (DAGs, cyclic graphs, noise). Every accepted command runs
// through a Kahn sort model; each result transfer is checked field by field.
// ---------------------------------------------------------------------------

module topological_sort_engine_tb;

    import tse_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int SETTLE      = 4;       // edge item retires after its S_EWR row write
    localparam int TAIL_CYCLES = 50;
    localparam int STALL_LIMIT = 20000;   // covers the silent busy span of a 32-vertex sort
    localparam int RAND_ITEMS  = 130;

    typedef enum logic [1:0] {
        ROW_CMD,
        ROW_CFG,
        ROW_DRAIN
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        cmd_t               c;
        logic [FIELD_W-1:0] cfg;
        bit                 typed;
        result_t            want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [FIELD_W-1:0] cfg_data;
    logic               result_valid;
    result_t            result;

    // model state
    logic [FIELD_W-1:0]      node_reg;
    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    int                      edge_total;

    result_t   step_out[$];
    result_t   pending_out[$];
    stim_row_t rows[$];
    int        queued_items;
    int        error_count;
    int        burst_left;
    int        stall_cycles;

    topological_sort_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #CLK_HALF clk = ~clk;

    function automatic result_t mk_result(int v, status_t st, logic l);
        result_t r;
        r.vertex = FIELD_W'(v);
        r.status = st;
        r.last   = l;
        return r;
    endfunction

    // Kahn sort on the model matrix; fills step_out with the item's results
    task automatic kahn_step(input cmd_t c);
        int      n;
        int      lim;
        int      f;
        int      t;
        int      head;
        int      tail;
        int      u;
        int      deg [MAX_VERTICES];
        int      rdy [MAX_VERTICES];
        result_t r;
        n = (int'(node_reg) > MAX_VERTICES) ? MAX_VERTICES : int'(node_reg);
        f = int'(c.from_vertex);
        t = int'(c.to_vertex);
        step_out.delete();
        case (c.mode)
            MODE_EDGE: begin
                lim = (n == 0) ? 0 : n * (n - 1) / 2;
                // limit test comes before the endpoint test
                if (edge_total >= lim)
                    step_out.push_back(mk_result(0, ST_TOOMANY, 1'b1));
                else if (f < 1 || f > n || t < 1 || t > n)
                    step_out.push_back(mk_result(0, ST_BADV, 1'b1));
                else
                begin
                    adj_rows[f-1][t-1] = 1'b1;
                    edge_total++;
                end
            end
            MODE_SORT: begin
                for (int j = 0; j < n; j++)
                begin
                    deg[j] = 0;
                    for (int i = 0; i < n; i++)
                        if (adj_rows[i][j])
                            deg[j]++;
                end
                head = 0;
                tail = 0;
                for (int j = 0; j < n; j++)
                    if (deg[j] == 0)
                    begin
                        rdy[tail] = j;
                        tail++;
                    end
                while (head < tail)
                begin
                    u = rdy[head];
                    head++;
                    step_out.push_back(mk_result(u + 1, ST_OK, 1'b0));
                    for (int j = 0; j < n; j++)
                        if (adj_rows[u][j])
                        begin
                            deg[j]--;
                            if (deg[j] == 0)
                            begin
                                rdy[tail] = j;
                                tail++;
                            end
                        end
                end
                if (step_out.size() != n)
                begin
                    step_out.delete();
                    step_out.push_back(mk_result(0, ST_CYCLE, 1'b1));
                end
                else if (n > 0)
                begin
                    r = step_out[n-1];
                    r.last = 1'b1;
                    step_out[n-1] = r;
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < MAX_VERTICES; i++)
                    adj_rows[i] = '0;
                edge_total = 0;
            end
            default: ;
        endcase
    endtask

    task automatic add_cmd(input mode_t m, input int f, input int t,
                           input bit typed, input int vtx, input status_t st);
        stim_row_t r;
        r.kind          = ROW_CMD;
        r.c.mode        = m;
        r.c.from_vertex = FIELD_W'(f);
        r.c.to_vertex   = FIELD_W'(t);
        r.cfg           = '0;
        r.typed         = typed;
        r.want          = mk_result(vtx, st, 1'b1);
        rows.push_back(r);
        if (m != MODE_NOP)
            queued_items++;
    endtask

    task automatic add_ctl(input row_kind_t k, input int v);
        stim_row_t r;
        r.kind  = k;
        r.c     = '0;
        r.cfg   = FIELD_W'(v);
        r.typed = 1'b0;
        r.want  = '0;
        rows.push_back(r);
    endtask

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_out.size() == 0)
                flag_mismatch($sformatf("unexpected result vertex=%0d status=%0d last=%0b",
                                        result.vertex, result.status, result.last));
            else
            begin
                want = pending_out.pop_front();
                if (result.vertex !== want.vertex)
                    flag_mismatch($sformatf("vertex %0d, want %0d",
                                            result.vertex, want.vertex));
                if (result.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d (vertex %0d)",
                                            result.status, want.status, want.vertex));
                if (result.last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b (vertex %0d)",
                                            result.last, want.last, want.vertex));
            end
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("** topological_sort_engine: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int        nsel;
        int        nact;
        int        lim;
        int        cap;
        int        ne;
        int        kind;
        int        i;
        int        j;
        int        s;
        int        tmp;
        int        perm [MAX_VERTICES];
        stim_row_t row;

        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        node_reg     = FIELD_W'(1);
        edge_total   = 0;
        error_count  = 0;
        burst_left   = 0;
        stall_cycles = 0;
        queued_items = 0;
        for (int k = 0; k < MAX_VERTICES; k++)
            adj_rows[k] = '0;

        // directed part; node_count is 1 out of reset
        add_cmd(MODE_EDGE, 1, 1, 1, 0, ST_TOOMANY);     // limit is zero at n = 1
        add_cmd(MODE_SORT, 0, 0, 1, 1, ST_OK);
        add_ctl(ROW_CFG, 0);
        add_cmd(MODE_EDGE, 63, 63, 1, 0, ST_TOOMANY);
        add_cmd(MODE_SORT, 63, 0, 0, 0, ST_OK);         // no vertices, no result
        add_ctl(ROW_CFG, 4);
        add_cmd(MODE_EDGE, 0, 2, 1, 0, ST_BADV);
        add_cmd(MODE_EDGE, 5, 1, 1, 0, ST_BADV);
        add_cmd(MODE_EDGE, 1, 63, 1, 0, ST_BADV);
        add_cmd(MODE_EDGE, 1, 2, 0, 0, ST_OK);
        add_cmd(MODE_EDGE, 2, 3, 0, 0, ST_OK);
        add_cmd(MODE_EDGE, 3, 4, 0, 0, ST_OK);
        add_cmd(MODE_SORT, 0, 0, 0, 0, ST_OK);
        add_cmd(MODE_EDGE, 4, 4, 0, 0, ST_OK);          // self loop
        add_cmd(MODE_SORT, 0, 0, 1, 0, ST_CYCLE);
        add_cmd(MODE_EDGE, 1, 3, 0, 0, ST_OK);
        add_cmd(MODE_EDGE, 1, 3, 0, 0, ST_OK);          // duplicate still counts
        add_cmd(MODE_EDGE, 2, 4, 1, 0, ST_TOOMANY);
        add_cmd(MODE_NOP, 42, 21, 0, 0, ST_OK);
        add_cmd(MODE_CLEAR, 21, 42, 0, 0, ST_OK);
        add_cmd(MODE_SORT, 0, 0, 0, 0, ST_OK);
        add_ctl(ROW_CFG, 63);                           // clamps to 32 vertices
        add_cmd(MODE_EDGE, 32, 1, 0, 0, ST_OK);
        add_cmd(MODE_EDGE, 63, 1, 1, 0, ST_BADV);
        add_cmd(MODE_SORT, 0, 0, 0, 0, ST_OK);
        add_ctl(ROW_CFG, 2);
        add_cmd(MODE_EDGE, 1, 2, 1, 0, ST_TOOMANY);
        add_cmd(MODE_SORT, 0, 0, 0, 0, ST_OK);          // row 32 is stale here

        // random graph phases, topped up to the item budget
        while (queued_items < RAND_ITEMS)
        begin
            s = $urandom_range(0, 9);
            if (s == 0)
                nsel = $urandom_range(0, 63);
            else if (s == 1)
                nsel = 32;
            else
                nsel = $urandom_range(2, 8);
            add_ctl(ROW_CFG, nsel);
            nact = (nsel > MAX_VERTICES) ? MAX_VERTICES : nsel;
            lim  = (nact == 0) ? 0 : nact * (nact - 1) / 2;
            repeat ($urandom_range(1, 3))
            begin
                add_cmd(MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                        0, 0, ST_OK);
                for (int k = 0; k < nact; k++)
                    perm[k] = k;
                for (int k = nact - 1; k > 0; k--)
                begin
                    s = $urandom_range(0, k);
                    tmp = perm[k];
                    perm[k] = perm[s];
                    perm[s] = tmp;
                end
                kind = $urandom_range(0, 9);
                cap  = (lim + 1 < 12) ? lim + 1 : 12;
                ne   = $urandom_range(0, cap);
                for (int k = 0; k < ne; k++)
                begin
                    if (kind <= 6 && nact >= 2)
                    begin
                        // forward edge along the permutation: acyclic
                        i = $urandom_range(0, nact - 2);
                        j = $urandom_range(i + 1, nact - 1);
                        add_cmd(MODE_EDGE, perm[i] + 1, perm[j] + 1, 0, 0, ST_OK);
                    end
                    else
                        add_cmd(mode_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                                $urandom_range(0, 63), 0, 0, ST_OK);
                end
                if (kind == 5 && nact >= 2)
                begin
                    i = $urandom_range(0, nact - 2);
                    j = $urandom_range(i + 1, nact - 1);
                    add_cmd(MODE_EDGE, perm[i] + 1, perm[j] + 1, 0, 0, ST_OK);
                    add_cmd(MODE_EDGE, perm[j] + 1, perm[i] + 1, 0, 0, ST_OK);
                end
                else if (kind == 6 && nact >= 1)
                begin
                    i = $urandom_range(0, nact - 1);
                    add_cmd(MODE_EDGE, perm[i] + 1, perm[i] + 1, 0, 0, ST_OK);
                end
                add_cmd(MODE_SORT, $urandom_range(0, 63), $urandom_range(0, 63),
                        0, 0, ST_OK);
                if ($urandom_range(0, 3) == 0)
                    add_ctl(ROW_DRAIN, 0);
            end
        end
        add_ctl(ROW_DRAIN, 0);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every iteration begins at a falling edge
        for (int idx = 0; idx < rows.size(); idx++)
        begin
            row = rows[idx];
            case (row.kind)
                ROW_CMD: begin
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            repeat ($urandom_range(10, 20)) @(negedge clk);
                        else
                            repeat ($urandom_range(1, 6)) @(negedge clk);
                        if ($urandom_range(0, 7) == 0)
                            burst_left = $urandom_range(40, 80);
                        else
                            burst_left = $urandom_range(1, 8);
                    end
                    start = 1'b1;
                    cmd   = row.c;
                    do
                        @(posedge clk);
                    while (busy);
                    kahn_step(row.c);
                    if (row.typed)
                        pending_out.push_back(row.want);
                    else
                        foreach (step_out[k])
                            pending_out.push_back(step_out[k]);
                    burst_left--;
                    @(negedge clk);
                    if (idx + 1 == rows.size() || rows[idx+1].kind != ROW_CMD ||
                        burst_left == 0)
                        start = 1'b0;
                end
                ROW_CFG: begin
                    while (pending_out.size() != 0 || busy)
                        @(negedge clk);
                    repeat (SETTLE) @(negedge clk);
                    cfg_valid = 1'b1;
                    cfg_data  = row.cfg;
                    do
                        @(posedge clk);
                    while (!cfg_ready);
                    node_reg = row.cfg;
                    @(negedge clk);
                    cfg_valid = 1'b0;
                end
                default: begin
                    while (pending_out.size() != 0)
                        @(negedge clk);
                end
            endcase
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_out.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_out.size()));
        if (error_count == 0)
            $display("** topological_sort_engine: PASSED **");
        else
            $display("** topological_sort_engine: FAILED **");
        $finish;
    end

endmodule
